// File: sv/hdt_pkg.sv
package hdt_pkg;

   // Table geometry
   localparam int SLOT_COUNT  = 256;
   localparam int SLOT_W      = $clog2(SLOT_COUNT);
   localparam int CNT_W       = SLOT_W + 1;
   localparam int GEN_WIDTH   = 16;
   localparam int GROUP_W     = 16;
   localparam int GROUP_BIT_W = $clog2(GROUP_W);
   localparam int GROUP_COUNT = SLOT_COUNT / GROUP_W;
   localparam int GROUP_IDX_W = $clog2(GROUP_COUNT);

   typedef logic [1:0] req_code_type;
   typedef logic [1:0] status_type;

   // Request codes
   localparam req_code_type REQ_ADD    = 2'd0;
   localparam req_code_type REQ_REMOVE = 2'd1;
   localparam req_code_type REQ_LOOKUP = 2'd2;

   // Status codes
   localparam status_type ST_OK      = 2'd0;
   localparam status_type ST_INVALID = 2'd1;
   localparam status_type ST_FULL    = 2'd2;

   // Result of the lowest-set-bit finder
   typedef struct packed {
      logic                   found;
      logic [GROUP_BIT_W-1:0] index;
   } prio_type;

endpackage

// File: sv/hdt_intf.sv
// Request channel
interface hdt_req_if import hdt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   req_code_type         req_type;
   logic [SLOT_W-1:0]    slot_id;
   logic [GEN_WIDTH-1:0] handle_gen;

   modport source (output valid, req_type, slot_id, handle_gen, input ready);
   modport sink   (input valid, req_type, slot_id, handle_gen, output ready);
endinterface

// Response channel
interface hdt_rsp_if import hdt_pkg::*; ();
   logic                 valid;
   logic                 ready;
   status_type           status;
   logic [SLOT_W-1:0]    out_slot;
   logic [GEN_WIDTH-1:0] out_gen;
   logic [SLOT_W-1:0]    dense_index;
   logic                 move_valid;
   logic [SLOT_W-1:0]    move_from;

   modport source (output valid, status, out_slot, out_gen, dense_index, move_valid,
                   move_from, input ready);
   modport sink   (input valid, status, out_slot, out_gen, dense_index, move_valid,
                   move_from, output ready);
endinterface

// File: sv/hdt_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data
module hdt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: sv/hdt_prio.sv
// Lowest-set-bit finder over one group; shared by both search levels
module hdt_prio import hdt_pkg::*; (
   input  logic [GROUP_W-1:0] bits,
   output prio_type           result
);

   always_comb begin
      result = '0;
      for (int i = GROUP_W - 1; i >= 0; i--) begin
         if (bits[i]) begin
            result.found = 1'b1;
            result.index = GROUP_BIT_W'(i);
         end
      end
   end

endmodule

// File: sv/generational_handle_table.sv
// Channel | Dir | Fields                                                   | Transfer
// req     | in  | req_type, slot_id, handle_gen                            | valid & ready
// rsp     | out | status, out_slot, out_gen, dense_index, move_valid,       | valid & ready
//         |     | move_from                                                |
// Add steps through accept, group search, slot search plus generation read, and
// commit (a full table skips the slot search); remove and lookup through accept,
// memory reads, check and commit, as set by the shared finder and registered reads.
// One request is in flight at a time; req.ready is high only when idle.
// The commit cycle waits while an earlier response is still not taken.
// Synchronous reset clears occupancy, generation-valid bits and the count; no
// clearing pass is needed.
module generational_handle_table import hdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   hdt_req_if.sink     req_chan,
   hdt_rsp_if.source   rsp_chan
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_GROUP = 3'd1;
   localparam logic [2:0] S_SLOT  = 3'd2;
   localparam logic [2:0] S_READ  = 3'd3;
   localparam logic [2:0] S_EXEC  = 3'd4;

   logic [2:0]             state_ff, state_in;
   logic [SLOT_COUNT-1:0]  used_ff, used_in;
   logic [SLOT_COUNT-1:0]  touched_ff, touched_in;
   logic [GROUP_COUNT-1:0] group_full_ff, group_full_in;
   logic [CNT_W-1:0]       dense_count_ff, dense_count_in;

   req_code_type           type_ff, type_in;
   logic [SLOT_W-1:0]      slot_ff, slot_in;
   logic [GEN_WIDTH-1:0]   gen_ff, gen_in;
   logic [GROUP_IDX_W-1:0] grp_ff, grp_in;
   logic                   full_ff, full_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             status_ff, status_in;
   logic [SLOT_W-1:0]      out_slot_ff, out_slot_in;
   logic [GEN_WIDTH-1:0]   out_gen_ff, out_gen_in;
   logic [SLOT_W-1:0]      dense_index_ff, dense_index_in;
   logic                   move_valid_ff, move_valid_in;
   logic [SLOT_W-1:0]      move_from_ff, move_from_in;

   // Finder and memory ports
   logic [GROUP_W-1:0]     prio_bits;
   prio_type               prio_res;

   logic                   gen_we, gen_re;
   logic [SLOT_W-1:0]      gen_waddr, gen_raddr;
   logic [GEN_WIDTH-1:0]   gen_wdata, gen_rdata;
   logic                   dense_we, dense_re;
   logic [SLOT_W-1:0]      dense_waddr, dense_raddr, dense_wdata, dense_rdata;
   logic                   owner_we, owner_re;
   logic [SLOT_W-1:0]      owner_waddr, owner_raddr, owner_wdata, owner_rdata;

   logic                   req_xfer, out_free, commit;
   logic [CNT_W-1:0]       last_full;
   logic [SLOT_W-1:0]      count_lo, dense_last;
   logic [GEN_WIDTH-1:0]   gen_cur, gen_next;
   logic                   handle_ok;
   logic [GROUP_W-1:0]     grp_used;

   hdt_prio u_prio (
      .bits   (prio_bits),
      .result (prio_res)
   );

   hdt_ram #(.WIDTH(GEN_WIDTH), .DEPTH(SLOT_COUNT)) u_gen_ram (
      .clock (clock),
      .we    (gen_we),
      .waddr (gen_waddr),
      .wdata (gen_wdata),
      .re    (gen_re),
      .raddr (gen_raddr),
      .rdata (gen_rdata)
   );

   hdt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_dense_ram (
      .clock (clock),
      .we    (dense_we),
      .waddr (dense_waddr),
      .wdata (dense_wdata),
      .re    (dense_re),
      .raddr (dense_raddr),
      .rdata (dense_rdata)
   );

   hdt_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_COUNT)) u_owner_ram (
      .clock (clock),
      .we    (owner_we),
      .waddr (owner_waddr),
      .wdata (owner_wdata),
      .re    (owner_re),
      .raddr (owner_raddr),
      .rdata (owner_rdata)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign commit         = (state_ff == S_EXEC) && out_free;

   assign last_full  = dense_count_ff - CNT_W'(1);
   assign dense_last = last_full[SLOT_W-1:0];
   assign count_lo   = dense_count_ff[SLOT_W-1:0];

   // Generation of the addressed slot; never-written entries read as zero
   assign gen_cur   = touched_ff[slot_ff] ? gen_rdata : '0;
   assign gen_next  = gen_cur + GEN_WIDTH'(1);
   assign handle_ok = used_ff[slot_ff] && (gen_cur == gen_ff);
   assign grp_used  = used_ff[{grp_ff, {GROUP_BIT_W{1'b0}}} +: GROUP_W];

   // Finder input: group level first, then bits of the chosen group
   always_comb begin
      if (state_ff == S_SLOT) begin
         prio_bits = ~grp_used;
      end else begin
         prio_bits = ~group_full_ff;
      end
   end

   // Sequencer, memory control and commit
   always_comb begin
      state_in       = state_ff;
      used_in        = used_ff;
      touched_in     = touched_ff;
      dense_count_in = dense_count_ff;
      type_in        = type_ff;
      slot_in        = slot_ff;
      gen_in         = gen_ff;
      grp_in         = grp_ff;
      full_in        = full_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      status_in      = status_ff;
      out_slot_in    = out_slot_ff;
      out_gen_in     = out_gen_ff;
      dense_index_in = dense_index_ff;
      move_valid_in  = move_valid_ff;
      move_from_in   = move_from_ff;

      gen_we      = 1'b0;
      gen_waddr   = slot_ff;
      gen_wdata   = gen_next;
      gen_re      = 1'b0;
      gen_raddr   = slot_ff;
      dense_we    = 1'b0;
      dense_waddr = slot_ff;
      dense_wdata = count_lo;
      dense_re    = 1'b0;
      dense_raddr = slot_ff;
      owner_we    = 1'b0;
      owner_waddr = count_lo;
      owner_wdata = slot_ff;
      owner_re    = 1'b0;
      owner_raddr = dense_last;

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               type_in = req_chan.req_type;
               slot_in = req_chan.slot_id;
               gen_in  = req_chan.handle_gen;
               if (req_chan.req_type == REQ_ADD) begin
                  state_in = S_GROUP;
               end else if (req_chan.req_type == REQ_REMOVE ||
                            req_chan.req_type == REQ_LOOKUP) begin
                  state_in = S_READ;
               end else begin
                  state_in = S_EXEC;
               end
            end
         end
         S_GROUP: begin
            grp_in   = prio_res.index;
            full_in  = !prio_res.found;
            state_in = prio_res.found ? S_SLOT : S_EXEC;
         end
         S_SLOT: begin
            slot_in   = {grp_ff, prio_res.index};
            gen_re    = 1'b1;
            gen_raddr = {grp_ff, prio_res.index};
            state_in  = S_EXEC;
         end
         S_READ: begin
            gen_re   = 1'b1;
            dense_re = 1'b1;
            owner_re = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (out_free) begin
               state_in       = S_IDLE;
               rsp_valid_in   = 1'b1;
               status_in      = ST_INVALID;
               out_slot_in    = slot_ff;
               out_gen_in     = gen_ff;
               dense_index_in = '0;
               move_valid_in  = 1'b0;
               move_from_in   = '0;
               case (type_ff)
                  REQ_ADD: begin
                     if (full_ff) begin
                        status_in   = ST_FULL;
                        out_slot_in = '0;
                        out_gen_in  = '0;
                     end else begin
                        status_in         = ST_OK;
                        out_gen_in        = gen_next;
                        dense_index_in    = count_lo;
                        gen_we            = 1'b1;
                        dense_we          = 1'b1;
                        owner_we          = 1'b1;
                        used_in[slot_ff]    = 1'b1;
                        touched_in[slot_ff] = 1'b1;
                        dense_count_in    = dense_count_ff + CNT_W'(1);
                     end
                  end
                  REQ_REMOVE: begin
                     if (handle_ok) begin
                        status_in        = ST_OK;
                        dense_index_in   = dense_rdata;
                        used_in[slot_ff] = 1'b0;
                        dense_count_in   = last_full;
                        // Fill the hole with the last dense entry
                        if (dense_rdata != dense_last) begin
                           move_valid_in = 1'b1;
                           move_from_in  = dense_last;
                           dense_we      = 1'b1;
                           dense_waddr   = owner_rdata;
                           dense_wdata   = dense_rdata;
                           owner_we      = 1'b1;
                           owner_waddr   = dense_rdata;
                           owner_wdata   = owner_rdata;
                        end
                     end
                  end
                  REQ_LOOKUP: begin
                     if (handle_ok) begin
                        status_in      = ST_OK;
                        dense_index_in = dense_rdata;
                     end
                  end
                  default: begin
                     status_in = ST_INVALID;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Per-group full flags follow the next occupancy
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         group_full_in[g] = &used_in[g*GROUP_W +: GROUP_W];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         used_ff        <= '0;
         touched_ff     <= '0;
         group_full_ff  <= '0;
         dense_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         used_ff        <= used_in;
         touched_ff     <= touched_in;
         group_full_ff  <= group_full_in;
         dense_count_ff <= dense_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      type_ff        <= type_in;
      slot_ff        <= slot_in;
      gen_ff         <= gen_in;
      grp_ff         <= grp_in;
      full_ff        <= full_in;
      status_ff      <= status_in;
      out_slot_ff    <= out_slot_in;
      out_gen_ff     <= out_gen_in;
      dense_index_ff <= dense_index_in;
      move_valid_ff  <= move_valid_in;
      move_from_ff   <= move_from_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = status_ff;
   assign rsp_chan.out_slot    = out_slot_ff;
   assign rsp_chan.out_gen     = out_gen_ff;
   assign rsp_chan.dense_index = dense_index_ff;
   assign rsp_chan.move_valid  = move_valid_ff;
   assign rsp_chan.move_from   = move_from_ff;

`ifndef SYNTH
   // Occupancy and dense count stay in step
   a_count_match: assert property (@(posedge clock) disable iff (reset)
      $countones(used_ff) == dense_count_ff)
      else $error("dense count differs from occupied slots");

   // Count never exceeds the table size
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      dense_count_ff <= CNT_W'(SLOT_COUNT))
      else $error("dense count out of range");

   // An add only ever claims a free slot
   a_add_free: assert property (@(posedge clock) disable iff (reset)
      (commit && type_ff == REQ_ADD && !full_ff) |-> !used_ff[slot_ff])
      else $error("add claimed an occupied slot");

   // An accepted request leaves idle on the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff != S_IDLE)
      else $error("sequencer idle right after a request transfer");
`endif

endmodule

// File: verif/hdt_checker.sv
// Watches both channels, predicts each response and compares it field by field
module hdt_checker import hdt_pkg::*; (
   input  logic clock,
   input  logic reset,
   hdt_req_if   req_mon,
   hdt_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      status_type           status;
      logic [SLOT_W-1:0]    slot;
      logic [GEN_WIDTH-1:0] gen;
      logic [SLOT_W-1:0]    dense;
      logic                 moved;
      logic [SLOT_W-1:0]    moved_from;
   } table_rsp_type;

   // Shadow copy of the table
   bit                   slot_busy [SLOT_COUNT];
   logic [GEN_WIDTH-1:0] slot_gen  [SLOT_COUNT];
   logic [SLOT_W-1:0]    slot_pos  [SLOT_COUNT];
   logic [SLOT_W-1:0]    pos_owner [SLOT_COUNT];
   int                   live_count;
   table_rsp_type        due_q[$];

   task automatic flag_mismatch(string field, int unsigned got, int unsigned want);
      $display("%0t ns: mismatch on %s, got %0h expected %0h", $time, field, got, want);
      mismatch_count++;
   endtask

   function automatic bit handle_live(logic [SLOT_W-1:0] slot, logic [GEN_WIDTH-1:0] gen);
      return slot_busy[slot] && slot_gen[slot] == gen;
   endfunction

   // Applies one request to the shadow table and returns its response
   function automatic table_rsp_type predict_response(req_code_type code,
                                                      logic [SLOT_W-1:0] slot,
                                                      logic [GEN_WIDTH-1:0] gen);
      table_rsp_type     r;
      bit                found;
      int                s;
      logic [SLOT_W-1:0] freed;
      logic [SLOT_W-1:0] last;
      logic [SLOT_W-1:0] owner;
      r = '0;
      r.status = ST_OK;
      r.slot = slot;
      r.gen = gen;
      found = 1'b0;
      s = 0;
      case (code)
         REQ_ADD: begin
            r.slot = '0;
            r.gen = '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
               if (!found && !slot_busy[i]) begin
                  found = 1'b1;
                  s = i;
               end
            end
            if (!found || live_count >= SLOT_COUNT) begin
               r.status = ST_FULL;
            end else begin
               slot_busy[s] = 1'b1;
               slot_gen[s] = slot_gen[s] + 1'b1;
               slot_pos[s] = SLOT_W'(live_count);
               pos_owner[live_count] = SLOT_W'(s);
               r.slot = SLOT_W'(s);
               r.gen = slot_gen[s];
               r.dense = SLOT_W'(live_count);
               live_count++;
            end
         end
         REQ_REMOVE: begin
            if (!handle_live(slot, gen)) begin
               r.status = ST_INVALID;
            end else begin
               freed = slot_pos[slot];
               last = SLOT_W'(live_count - 1);
               // last dense entry fills the hole
               if (freed != last) begin
                  owner = pos_owner[last];
                  slot_pos[owner] = freed;
                  pos_owner[freed] = owner;
                  r.moved = 1'b1;
                  r.moved_from = last;
               end
               slot_busy[slot] = 1'b0;
               live_count--;
               r.dense = freed;
            end
         end
         REQ_LOOKUP: begin
            if (!handle_live(slot, gen))
               r.status = ST_INVALID;
            else
               r.dense = slot_pos[slot];
         end
         default: begin
            r.status = ST_INVALID;
         end
      endcase
      return r;
   endfunction

   // Predict on request transfers, compare on response transfers
   always @(posedge clock) begin : watch
      table_rsp_type want;
      if (reset) begin
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_busy[i] = 1'b0;
            slot_gen[i] = '0;
            slot_pos[i] = '0;
            pos_owner[i] = '0;
         end
         live_count = 0;
         due_q.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            due_q.push_back(predict_response(req_mon.req_type, req_mon.slot_id,
                                             req_mon.handle_gen));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_q.size() == 0) begin
               flag_mismatch("unexpected response", 1, 0);
            end else begin
               want = due_q.pop_front();
               if (rsp_mon.status !== want.status)
                  flag_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.out_slot !== want.slot)
                  flag_mismatch("out_slot", rsp_mon.out_slot, want.slot);
               if (rsp_mon.out_gen !== want.gen)
                  flag_mismatch("out_gen", rsp_mon.out_gen, want.gen);
               if (rsp_mon.dense_index !== want.dense)
                  flag_mismatch("dense_index", rsp_mon.dense_index, want.dense);
               if (rsp_mon.move_valid !== want.moved)
                  flag_mismatch("move_valid", rsp_mon.move_valid, want.moved);
               if (rsp_mon.move_from !== want.moved_from)
                  flag_mismatch("move_from", rsp_mon.move_from, want.moved_from);
            end
         end
      end
      results_due <= due_q.size();
   end

endmodule

// File: verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hdt_pkg::*;

   localparam req_code_type REQ_UNKNOWN = 2'd3;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 380;

   typedef struct packed {
      logic [SLOT_W-1:0]    slot;
      logic [GEN_WIDTH-1:0] gen;
   } handle_type;

   logic clock;
   logic reset;
   int   mismatch_count;
   int   results_due;
   int   cycle_count = 0;
   int   idle_pct = 0;
   int   stall_pct = 0;
   int   hold_req = 0;
   int   full_seen = 0;
   bit   fill_mode = 1'b1;
   int   mode_items = 0;

   handle_type   live_pool[$];
   handle_type   stale_pool[$];
   req_code_type sent_codes[$];

   hdt_req_if req_if();
   hdt_rsp_if rsp_if();

   generational_handle_table i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   hdt_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_if),
      .rsp_mon        (rsp_if),
      .mismatch_count (mismatch_count),
      .results_due    (results_due)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // Receiver: random stalls plus an occasional long hold-off
   initial begin : receiver
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Learn live handles from add responses; sampled mid-cycle, before the transfer edge
   always @(negedge clock) begin
      req_code_type code;
      if (!reset && rsp_if.valid && rsp_if.ready && sent_codes.size() != 0) begin
         code = sent_codes.pop_front();
         if (rsp_if.status == ST_FULL)
            full_seen++;
         else if (code == REQ_ADD && rsp_if.status == ST_OK)
            live_pool.push_back('{rsp_if.out_slot, rsp_if.out_gen});
      end
   end

   // Offer one request and hold it until the transfer
   task automatic issue(req_code_type code, logic [SLOT_W-1:0] slot,
                        logic [GEN_WIDTH-1:0] gen);
      while ($urandom_range(99) < idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.req_type   <= code;
      req_if.slot_id    <= slot;
      req_if.handle_gen <= gen;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sent_codes.push_back(code);
   endtask

   task automatic pause_until_drained();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Malformed or stale handles and unknown codes
   task automatic noise_item();
      handle_type   h;
      req_code_type code;
      code = $urandom_range(1) ? REQ_REMOVE : REQ_LOOKUP;
      h = '{SLOT_W'($urandom), GEN_WIDTH'($urandom)};
      case ($urandom_range(3))
         0: if (stale_pool.size() != 0)
               h = stale_pool[$urandom_range(stale_pool.size() - 1)];
         1: if (live_pool.size() != 0) begin
               h = live_pool[$urandom_range(live_pool.size() - 1)];
               h.gen = h.gen ^ (GEN_WIDTH'(1) << $urandom_range(GEN_WIDTH - 1));
            end
         2: ;
         default: code = REQ_UNKNOWN;
      endcase
      issue(code, h.slot, h.gen);
   endtask

   // Fill mode favors adds until the table reports full; drain mode empties it again
   task automatic random_item();
      int         pick;
      int         k;
      int         add_cut;
      int         remove_cut;
      int         lookup_cut;
      handle_type h;
      pick = $urandom_range(99);
      add_cut    = fill_mode ? 70 : 15;
      remove_cut = fill_mode ? 82 : 70;
      lookup_cut = fill_mode ? 94 : 90;
      if (pick < add_cut) begin
         issue(REQ_ADD, SLOT_W'($urandom), GEN_WIDTH'($urandom));
      end else if (pick < lookup_cut && live_pool.size() != 0) begin
         k = $urandom_range(live_pool.size() - 1);
         h = live_pool[k];
         if (pick < remove_cut) begin
            live_pool.delete(k);
            stale_pool.push_back(h);
            if (stale_pool.size() > 64)
               void'(stale_pool.pop_front());
            issue(REQ_REMOVE, h.slot, h.gen);
         end else begin
            issue(REQ_LOOKUP, h.slot, h.gen);
         end
      end else begin
         noise_item();
      end
      mode_items++;
      if (fill_mode ? (full_seen >= 12 || mode_items > 700)
                    : (live_pool.size() <= 2 || mode_items > 700)) begin
         fill_mode = !fill_mode;
         full_seen = 0;
         mode_items = 0;
      end
   endtask

   // Stimulus and verdict
   initial begin : stimulus
      int                   idle_tab  [4];
      int                   stall_tab [4];
      logic [GEN_WIDTH-1:0] g;
      idle_tab  = '{0, 64, 0, 20};
      stall_tab = '{0, 0, 64, 20};
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.req_type   <= REQ_ADD;
      req_if.slot_id    <= '0;
      req_if.handle_gen <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table, moves, last-entry removal, stale and unknown requests
      issue(REQ_LOOKUP, 8'd0, 16'd0);
      issue(REQ_REMOVE, 8'd255, 16'hFFFF);
      issue(REQ_UNKNOWN, 8'd255, 16'hFFFF);
      issue(REQ_ADD, 8'd0, 16'd0);
      issue(REQ_ADD, 8'd255, 16'hFFFF);
      issue(REQ_ADD, 8'd0, 16'd0);
      issue(REQ_LOOKUP, 8'd1, 16'd1);
      issue(REQ_LOOKUP, 8'd1, 16'd2);
      issue(REQ_LOOKUP, 8'd3, 16'd1);
      issue(REQ_REMOVE, 8'd2, 16'd1);
      issue(REQ_REMOVE, 8'd0, 16'd1);
      issue(REQ_LOOKUP, 8'd1, 16'd1);
      issue(REQ_ADD, 8'd0, 16'd0);
      issue(REQ_REMOVE, 8'd0, 16'd1);
      issue(REQ_REMOVE, 8'd1, 16'd1);
      issue(REQ_LOOKUP, 8'd0, 16'd2);
      issue(REQ_REMOVE, 8'd0, 16'd2);
      issue(REQ_UNKNOWN, 8'd0, 16'd0);
      issue(REQ_LOOKUP, 8'd0, 16'd2);
      pause_until_drained();

      // Reuse slot 0 a few times on an otherwise empty table
      g = 16'd2;
      repeat (8) begin
         g = g + 1'b1;
         issue(REQ_ADD, 8'd0, 16'd0);
         issue(REQ_REMOVE, 8'd0, g);
      end
      pause_until_drained();
      live_pool.delete();
      full_seen = 0;

      // Random traffic under each idling mix
      for (int ph = 0; ph < 4; ph++) begin
         idle_pct = idle_tab[ph];
         stall_pct <= stall_tab[ph];
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // long receiver hold-off while requests keep coming
            if ((ph == 0 || ph == 2) && i == 120)
               hold_req <= hold_req + 1;
            random_item();
         end
         pause_until_drained();
      end

      if (mismatch_count == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule

// File: filelist.f
sv/hdt_pkg.sv
sv/hdt_intf.sv
sv/hdt_ram.sv
sv/hdt_prio.sv
sv/generational_handle_table.sv
verif/hdt_checker.sv
verif/tb.sv
